FILE: rtl/core/erma_pkg.sv
// ----------------------------------------------------------------------------
// erma_pkg
// Shared types and constants of the edge reset moving average filter.
// ----------------------------------------------------------------------------
package erma_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int THRESH_BITS = 12;
	localparam int CAPLEN_BITS = 16;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd600;
	localparam logic [CAPLEN_BITS-1:0] CAPLEN_RESET = 16'd1024;

	// queue depths between front and back, and at the result side
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [0:0] {
		CFG_EDGE_THRESHOLD = 1'b0,
		CFG_CAPTURE_LENGTH = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PRIME = 2'd1,
		PH_RUN   = 2'd2
	} phase_t;

	typedef enum logic [0:0] {
		CMD_PRIME = 1'b0,
		CMD_RUN   = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   start_capture;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] filtered_value;
		logic                   edge_seen;
		logic                   capture_done;
	} out_item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		cmd_kind_t              kind;
		logic                   first;
		logic                   done;
	} cmd_t;

	typedef struct packed {
		logic cmd_pop;
		logic res_push;
	} back_stat_t;

endpackage

FILE: rtl/core/edge_reset_moving_average.sv
// ----------------------------------------------------------------------------
// edge_reset_moving_average
// Moving average over WINDOW samples with a step detector that snaps the
// window to a new level, counted captures and queue style ports.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            item   (sample, start_capture)
//  result    pop / empty            result (filtered_value, edge_seen, capture_done)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one sample per cycle sustained while full stays low; a result reaches the ports
//  through the command queue, the back part's registers and the result queue.
//  the running sum update with the step test is a loop through one register, the sum.
//  reset clears phase, counters, sum and queues; history is written by priming.
//  a stalled result side fills the result queue, then the command queue,
//  and only then raises full.
// ----------------------------------------------------------------------------
module edge_reset_moving_average #(
	parameter int WINDOW = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  erma_pkg::in_item_t                    item,
	input  logic                                  pop,
	output logic                                  empty,
	output erma_pkg::out_item_t                   result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  erma_pkg::cfg_index_t                  cfg_index,
	input  logic [erma_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int CMD_LVL_W = $clog2(erma_pkg::CMD_DEPTH + 1);

	logic [erma_pkg::THRESH_BITS-1:0] thresh_q;
	logic [erma_pkg::CAPLEN_BITS-1:0] caplen_q;
	logic                             take;
	logic                             cmd_push;
	erma_pkg::cmd_t                   cmd_in;
	erma_pkg::cmd_t                   cmd_head;
	logic                             cmd_full;
	logic                             cmd_empty;
	logic [CMD_LVL_W-1:0]             cmd_level;
	erma_pkg::back_stat_t             back_stat;
	erma_pkg::out_item_t              back_res;
	logic                             out_full;
	logic [erma_pkg::OUT_LVL_W-1:0]   out_level;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;
	assign take      = push && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= erma_pkg::THRESH_RESET;
			caplen_q <= erma_pkg::CAPLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				erma_pkg::CFG_EDGE_THRESHOLD: thresh_q <= cfg_data[erma_pkg::THRESH_BITS-1:0];
				erma_pkg::CFG_CAPTURE_LENGTH: caplen_q <= cfg_data[erma_pkg::CAPLEN_BITS-1:0];
				default: thresh_q <= thresh_q;
			endcase
		end
	end

	erma_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.item           (item),
		.capture_length (caplen_q),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in)
	);

	erma_fifo #(
		.WIDTH($bits(erma_pkg::cmd_t)),
		.DEPTH(erma_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (back_stat.cmd_pop),
		.rd_data (cmd_head),
		.full    (cmd_full),
		.empty   (cmd_empty),
		.level   (cmd_level)
	);

	erma_back #(
		.WINDOW(WINDOW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_head),
		.cmd_empty      (cmd_empty),
		.edge_threshold (thresh_q),
		.out_level      (out_level),
		.stat           (back_stat),
		.res            (back_res)
	);

	erma_fifo #(
		.WIDTH($bits(erma_pkg::out_item_t)),
		.DEPTH(erma_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_stat.res_push),
		.wr_data (back_res),
		.rd_en   (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty),
		.level   (out_level)
	);

`ifndef SYNTHESIS
	// a result never meets a full result queue
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.res_push |-> !out_full)
		else $error("result pushed into full queue");

	// every run command taken by the back part yields one result next cycle
	a_run_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(back_stat.cmd_pop && cmd_head.kind == erma_pkg::CMD_RUN) |=> back_stat.res_push)
		else $error("run command lost its result");

	// the back part only pops a waiting command
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.cmd_pop |-> (cmd_level != '0))
		else $error("command popped from empty queue");
`endif

endmodule

FILE: rtl/core/erma_fifo.sv
// ----------------------------------------------------------------------------
// erma_fifo
// Small register based first-in first-out queue with fill level.
// ----------------------------------------------------------------------------
module erma_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (level_q == LVL_W'(DEPTH));
	assign empty = (level_q == '0);
	assign level = level_q;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/core/erma_front.sv
// ----------------------------------------------------------------------------
// erma_front
// Accepts samples, tracks capture phase and counts, and issues commands.
// ----------------------------------------------------------------------------
module erma_front #(
	parameter int WINDOW = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  erma_pkg::in_item_t                  item,
	input  logic [erma_pkg::CAPLEN_BITS-1:0]    capture_length,
	output logic                                cmd_push,
	output erma_pkg::cmd_t                      cmd
);

	localparam int CNT_W = $clog2(WINDOW + 1);

	erma_pkg::phase_t                   phase_q;
	erma_pkg::phase_t                   phase_d;
	logic [CNT_W-1:0]                   prime_cnt_q;
	logic [CNT_W-1:0]                   prime_inc;
	logic [erma_pkg::CAPLEN_BITS-1:0]   results_q;
	logic [erma_pkg::CAPLEN_BITS-1:0]   results_inc;

	assign prime_inc   = prime_cnt_q + 1'b1;
	assign results_inc = results_q + 1'b1;

	// next state
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			if (item.start_capture) begin
				phase_d = erma_pkg::PH_PRIME;
			end else begin
				unique case (phase_q)
					erma_pkg::PH_IDLE: begin
						phase_d = erma_pkg::PH_IDLE;
					end
					erma_pkg::PH_PRIME: begin
						if (prime_inc == CNT_W'(WINDOW)) begin
							phase_d = erma_pkg::PH_RUN;
						end
					end
					erma_pkg::PH_RUN: begin
						if (results_inc == capture_length) begin
							phase_d = erma_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_d = erma_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// command to the back part
	always_comb begin
		cmd_push   = take && (item.start_capture || phase_q != erma_pkg::PH_IDLE);
		cmd.sample = item.sample;
		cmd.kind   = (item.start_capture || phase_q == erma_pkg::PH_PRIME)
			? erma_pkg::CMD_PRIME : erma_pkg::CMD_RUN;
		cmd.first  = item.start_capture;
		cmd.done   = (results_inc == capture_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= erma_pkg::PH_IDLE;
			prime_cnt_q <= '0;
			results_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (take) begin
				if (item.start_capture) begin
					prime_cnt_q <= CNT_W'(1);
					results_q   <= '0;
				end else if (phase_q == erma_pkg::PH_PRIME) begin
					prime_cnt_q <= prime_inc;
				end else if (phase_q == erma_pkg::PH_RUN) begin
					results_q <= results_inc;
				end
			end
		end
	end

endmodule

FILE: rtl/core/erma_back.sv
// ----------------------------------------------------------------------------
// erma_back
// Carries out commands: history ring, running sum, step detect, averaging.
// ----------------------------------------------------------------------------
module erma_back #(
	parameter int WINDOW = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  erma_pkg::cmd_t                      cmd,
	input  logic                                cmd_empty,
	input  logic [erma_pkg::THRESH_BITS-1:0]    edge_threshold,
	input  logic [erma_pkg::OUT_LVL_W-1:0]      out_level,
	output erma_pkg::back_stat_t                stat,
	output erma_pkg::out_item_t                 res
);

	localparam int SB    = erma_pkg::SAMPLE_BITS;
	localparam int LW    = erma_pkg::OUT_LVL_W;
	localparam int IDX_W = $clog2(WINDOW);
	localparam int SUM_W = $clog2(WINDOW * ((1 << SB) - 1) + 1);
	localparam int SH    = SUM_W + IDX_W;
	localparam int PROD_W = 2 * SUM_W + 1;
	// exact reciprocal for every sum below 2**SUM_W
	localparam longint unsigned RECIP = ((64'd1 << SH) + WINDOW - 1) / WINDOW;

	logic [SB-1:0]     hist_mem [WINDOW];
	logic [WINDOW-1:0] valid_q;
	logic [WINDOW-1:0] valid_d;
	logic [IDX_W-1:0]  wpos_q;
	logic [IDX_W-1:0]  wpos_d;
	logic [IDX_W-1:0]  waddr;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_d;
	logic [SUM_W-1:0]  snap_sum;
	logic [SB-1:0]     snap_q;
	logic [SB-1:0]     snap_d;
	logic [SB-1:0]     rd_data_q;
	logic              rd_valid_q;
	logic              res_v_s1;
	logic              edge_s1;
	logic              done_s1;
	logic [LW:0]       pending;
	logic              go;
	logic              we;
	logic              edge_hit;
	logic [PROD_W-1:0] prod;
	logic [SB-1:0]     avg;
	logic [SB-1:0]     old_val;
	logic [SB-1:0]     diff;

	// keep room for a result that is still on its way into the queue
	assign pending = {1'b0, out_level} + {{LW{1'b0}}, res_v_s1};
	assign go      = !cmd_empty && (pending < (LW + 1)'(erma_pkg::OUT_DEPTH));

	// average of the current sum, for the step test and for the result
	assign prod     = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign avg      = prod[SH +: SB];
	assign old_val  = rd_valid_q ? rd_data_q : snap_q;
	assign diff     = (cmd.sample > avg) ? (cmd.sample - avg) : (avg - cmd.sample);
	assign edge_hit = go && (cmd.kind == erma_pkg::CMD_RUN) && (diff > edge_threshold);
	assign snap_sum = SUM_W'(int'(cmd.sample) * WINDOW);

	always_comb begin
		we      = 1'b0;
		waddr   = wpos_q;
		wpos_d  = wpos_q;
		sum_d   = sum_q;
		snap_d  = snap_q;
		valid_d = valid_q;
		if (go) begin
			unique case (cmd.kind)
				erma_pkg::CMD_PRIME: begin
					waddr = cmd.first ? '0 : wpos_q;
					we    = 1'b1;
					sum_d = cmd.first ? SUM_W'(cmd.sample) : sum_q + SUM_W'(cmd.sample);
					valid_d[waddr] = 1'b1;
					wpos_d = (waddr == IDX_W'(WINDOW - 1)) ? '0 : waddr + 1'b1;
				end
				erma_pkg::CMD_RUN: begin
					if (edge_hit) begin
						// whole window snaps to the sample, ring position kept
						valid_d = '0;
						snap_d  = cmd.sample;
						sum_d   = snap_sum;
					end else begin
						we    = 1'b1;
						sum_d = sum_q - SUM_W'(old_val) + SUM_W'(cmd.sample);
						valid_d[waddr] = 1'b1;
						wpos_d = (waddr == IDX_W'(WINDOW - 1)) ? '0 : waddr + 1'b1;
					end
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			wpos_q     <= '0;
			sum_q      <= '0;
			rd_valid_q <= 1'b0;
			res_v_s1   <= 1'b0;
		end else begin
			valid_q    <= valid_d;
			wpos_q     <= wpos_d;
			sum_q      <= sum_d;
			rd_valid_q <= valid_d[wpos_d];
			res_v_s1   <= go && (cmd.kind == erma_pkg::CMD_RUN);
		end
	end

	// history ring; the entry at the next position is prefetched every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem[waddr] <= cmd.sample;
		end
		rd_data_q <= hist_mem[wpos_d];
		snap_q    <= snap_d;
		edge_s1   <= edge_hit;
		done_s1   <= cmd.done;
	end

	assign stat.cmd_pop  = go;
	assign stat.res_push = res_v_s1;

	assign res.filtered_value = avg;
	assign res.edge_seen      = edge_s1;
	assign res.capture_done   = done_s1;

endmodule

FILE: tb/sv/edge_reset_moving_average_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_reset_moving_average_tb
// Drives converter samples through the queue ports with random gaps on both
// sides, predicts the random filtered results with an in-bench copy of the
// window, step detector and capture counter, and compares field by field.
// A short directed table with its own expected values comes first, then
// random captures under a series of threshold and capture length settings.
// ----------------------------------------------------------------------------
module edge_reset_moving_average_tb;
	import erma_pkg::*;

	localparam int WIN         = 16;
	localparam int LATENCY     = 3;
	localparam int MAX_GAP     = 16;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 80;
	localparam int SMAX        = (1 << SAMPLE_BITS) - 1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push;
	logic                     full;
	in_item_t                 item;
	logic                     pop;
	logic                     empty;
	out_item_t                result;
	logic                     cfg_valid;
	logic                     cfg_ready;
	cfg_index_t               cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	edge_reset_moving_average #(.WINDOW(WIN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// filter state as the bench sees it
	logic [SAMPLE_BITS-1:0] hist [WIN];
	logic [15:0]            wsum;
	logic [3:0]             wpos;
	logic [4:0]             primed;
	logic [15:0]            made;
	phase_t                 ph;
	logic [THRESH_BITS-1:0] thr;
	logic [CAPLEN_BITS-1:0] caplen;

	out_item_t averages_due[$];
	int        mismatches = 0;
	int        samples_fed = 0;
	bit        send_calm = 1'b0;
	bit        recv_calm = 1'b0;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   start;
		logic                   known;
		logic [SAMPLE_BITS-1:0] fv;
		logic                   es;
		logic                   cd;
	} plan_row_t;

	// capture length is 4 and threshold 600 while this runs
	plan_row_t plan [0:23] = '{
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},	// idle, ignored
		'{12'd4095, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},	// window full
		'{12'd4095, 1'b0, 1'b1, 12'd4095, 1'b0, 1'b0},
		'{12'd0,    1'b0, 1'b1, 12'd0, 1'b1, 1'b0},	// step down snaps window
		'{12'd600,  1'b0, 1'b1, 12'd37, 1'b0, 1'b0},	// deviation equal to threshold
		'{12'd0,    1'b0, 1'b1, 12'd37, 1'b0, 1'b1},	// last of the capture
		'{12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},	// idle again, ignored
		'{12'd100,  1'b1, 1'b0, 12'd0, 1'b0, 1'b0},
		'{12'd200,  1'b1, 1'b0, 12'd0, 1'b0, 1'b0}	// restart while priming
	};

	function automatic void clear_filter();
		foreach (hist[k])
			hist[k] = '0;
		wsum = '0;
		wpos = '0;
		primed = '0;
		made = '0;
	endfunction

	function automatic bit predict_average(input in_item_t it, output out_item_t r);
		logic [SAMPLE_BITS-1:0] s;
		logic [SAMPLE_BITS-1:0] avg;
		logic [SAMPLE_BITS-1:0] diff;
		bit                     hit;
		r = '0;
		s = it.sample;
		if (it.start_capture) begin
			clear_filter();
			ph = PH_PRIME;
		end
		if (ph == PH_PRIME) begin
			if (primed < WIN) begin
				hist[primed[3:0]] = s;
				wsum = wsum + 16'(s);
				primed = primed + 1'b1;
			end
			if (primed >= WIN) begin
				wpos = '0;
				ph = PH_RUN;
			end
			return 1'b0;
		end
		if (ph != PH_RUN)
			return 1'b0;
		avg = SAMPLE_BITS'(wsum / WIN);
		diff = (s > avg) ? s - avg : avg - s;
		hit = diff > thr;
		if (hit) begin
			foreach (hist[k])
				hist[k] = s;
			wsum = 16'(s * WIN);
		end else begin
			// oldest entry leaves the window
			wsum = wsum - 16'(hist[wpos]) + 16'(s);
			hist[wpos] = s;
			wpos = (wpos == WIN - 1) ? '0 : wpos + 1'b1;
		end
		made = made + 1'b1;
		r.filtered_value = SAMPLE_BITS'(wsum / WIN);
		r.edge_seen = hit;
		r.capture_done = (made == caplen);
		if (made == caplen)
			ph = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] near(input int level, input int spread);
		int v;
		v = level + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > SMAX)
			v = SMAX;
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// called at a falling edge, returns at a falling edge with push still high
	task automatic send_item(input logic [SAMPLE_BITS-1:0] s, input logic st,
			input bit known, input out_item_t want);
		int        gap;
		in_item_t  it;
		out_item_t r;
		bit        made_one;
		it.sample = s;
		it.start_capture = st;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		item = it;
		do @(posedge clk); while (full);
		if (!(ph == PH_IDLE && !st))
			samples_fed++;
		made_one = predict_average(it, r);
		if (known)
			averages_due.push_back(want);
		else if (made_one)
			averages_due.push_back(r);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_EDGE_THRESHOLD: thr = data[THRESH_BITS-1:0];
			CFG_CAPTURE_LENGTH: caplen = data[CAPLEN_BITS-1:0];
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// priming samples give no result, so allow the pipe to empty after the last one
	task automatic drain();
		push = 1'b0;
		while (averages_due.size() != 0)
			@(negedge clk);
		repeat (4 * LATENCY) @(negedge clk);
	endtask

	task automatic check_average(input out_item_t got);
		out_item_t want;
		if (averages_due.size() == 0) begin
			report($sformatf("result %0d/%0b/%0b with nothing expected",
				got.filtered_value, got.edge_seen, got.capture_done));
			return;
		end
		want = averages_due.pop_front();
		if (got.filtered_value != want.filtered_value)
			report($sformatf("filtered_value %0d, expected %0d",
				got.filtered_value, want.filtered_value));
		if (got.edge_seen != want.edge_seen)
			report($sformatf("edge_seen %0b, expected %0b", got.edge_seen, want.edge_seen));
		if (got.capture_done != want.capture_done)
			report($sformatf("capture_done %0b, expected %0b",
				got.capture_done, want.capture_done));
	endtask

	// result side
	initial begin
		out_item_t got;
		int        gap;
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			got = result;
			// compare once the sender has logged this edge's transfer
			@(negedge clk);
			check_average(got);
		end
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int        k;
		int        fed_at;
		int        level;
		int        spread;
		logic [SAMPLE_BITS-1:0] s;
		logic [CFG_DATA_BITS-1:0] t;
		logic [CFG_DATA_BITS-1:0] c;
		out_item_t want;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_EDGE_THRESHOLD;
		cfg_data = '0;
		thr = THRESH_RESET;
		caplen = CAPLEN_RESET;
		clear_filter();
		ph = PH_IDLE;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(CFG_EDGE_THRESHOLD, 16'd600);
		write_reg(CFG_CAPTURE_LENGTH, 16'd4);
		foreach (plan[i]) begin
			want.filtered_value = plan[i].fv;
			want.edge_seen = plan[i].es;
			want.capture_done = plan[i].cd;
			send_item(plan[i].sample, plan[i].start, plan[i].known, want);
		end

		for (k = 0; k < PHASES; k++) begin
			drain();
			case (k % 5)
				0: t = 16'd0;
				1: t = 16'(SMAX);
				2: t = 16'd600;
				3: t = 16'($urandom_range(0, SMAX));
				default: t = 16'($urandom_range(1, 64));
			endcase
			if (k == 6)
				c = 16'd0;	// wraps, capture never ends here
			else begin
				case (k % 4)
					0: c = 16'd1;
					1: c = 16'hFFFF;
					default: c = 16'($urandom_range(2, 48));
				endcase
			end
			write_reg(CFG_EDGE_THRESHOLD, t);
			write_reg(CFG_CAPTURE_LENGTH, c);
			send_calm = (k % 3 == 0);
			recv_calm = (k % 3 == 1);
			fed_at = samples_fed;
			while (samples_fed - fed_at < PHASE_ITEMS) begin
				// stray samples without a start
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 3))
						send_item(12'($urandom_range(0, SMAX)), 1'b0, 1'b0, '0);
				level = $urandom_range(0, SMAX);
				case ($urandom_range(0, 2))
					0: spread = 4;
					1: spread = 64;
					default: spread = 800;
				endcase
				send_item(near(level, spread), 1'b1, 1'b0, '0);
				while (ph != PH_IDLE && samples_fed - fed_at < PHASE_ITEMS) begin
					if ($urandom_range(0, 99) < 3)
						level = $urandom_range(0, SMAX);
					if ($urandom_range(0, 9) == 0)
						s = 12'($urandom_range(0, SMAX));
					else
						s = near(level, spread);
					send_item(s, $urandom_range(0, 49) == 0, 1'b0, '0);
				end
			end
		end
		drain();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: edge_reset_moving_average.f
rtl/core/erma_pkg.sv
rtl/core/erma_fifo.sv
rtl/core/erma_front.sv
rtl/core/erma_back.sv
rtl/core/edge_reset_moving_average.sv
tb/sv/edge_reset_moving_average_tb.sv
